[rtl/core/elu3_pkg.sv]
package elu3_pkg;

  localparam int DefValueBits = 24;
  localparam int DefFracBits  = 16;
  localparam int DefAxes      = 3;
  localparam int MaxAxes      = 3;

endpackage

[rtl/core/elu3_front.sv]
module elu3_front #(
  parameter int VALUE_BITS = elu3_pkg::DefValueBits,
  parameter int AXES       = elu3_pkg::DefAxes
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         ins_req,
  input  logic signed [VALUE_BITS-1:0] pos_v [3],
  input  logic signed [VALUE_BITS-1:0] neg_v [3],
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic                         q_inside,
  output logic                         q_undef,
  output logic signed [VALUE_BITS-1:0] q_s [3]
);
  import elu3_pkg::*;

  localparam logic signed [VALUE_BITS-1:0] MaxV = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic signed [VALUE_BITS-1:0] s_c [3];
  logic [2:0]                   und_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VALUE_BITS-1:0] p, n;
      logic pu, nu;
      p  = pos_v[i];
      n  = neg_v[i];
      pu = (p >= MaxV) || (p <= -MaxV);
      nu = (n >= MaxV) || (n <= -MaxV);
      if (ins_req) begin
        p = -p;
        n = -n;
      end
      und_c[i] = 1'b0;
      if (i >= AXES) begin
        s_c[i]   = '0;
        und_c[i] = 1'b1;
      end else if (!pu && !nu) begin
        s_c[i] = (p < n) ? p : n;
      end else if (!pu) begin
        s_c[i] = p;
      end else if (!nu) begin
        s_c[i] = n;
      end else begin
        s_c[i]   = '0;
        und_c[i] = 1'b1;
      end
    end
  end

  // Two-entry queue.
  logic                         v [2];
  logic                         qi [2];
  logic                         qu [2];
  logic signed [VALUE_BITS-1:0] qs [2][3];
  logic                         wp, rp;

  assign in_ready = !(v[0] && v[1]);
  assign q_valid  = v[rp];
  assign q_inside = qi[rp];
  assign q_undef  = qu[rp];
  assign q_s      = qs[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      qi[wp] <= ins_req;
      qu[wp] <= &und_c;
      qs[wp] <= s_c;
    end
    if (rst) begin
      v[0] <= 1'b0;
      v[1] <= 1'b0;
      wp   <= 1'b0;
      rp   <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        v[rp] <= 1'b0;
        rp    <= ~rp;
      end
      if (in_valid && in_ready) begin
        v[wp] <= 1'b1;
        wp    <= ~wp;
      end
    end
  end

endmodule

[rtl/core/elu3_back.sv]
module elu3_back #(
  parameter int VALUE_BITS = elu3_pkg::DefValueBits,
  parameter int FRAC_BITS  = elu3_pkg::DefFracBits,
  parameter int AXES       = elu3_pkg::DefAxes
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic                         q_inside,
  input  logic                         q_undef,
  input  logic signed [VALUE_BITS-1:0] q_s [3],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] distance,
  output logic                         all_undefined
);
  import elu3_pkg::*;

  localparam int SW = 2*VALUE_BITS + 4;     // sum of squares width
  localparam int RW = VALUE_BITS + 2;       // root width
  localparam int SQ_BITS = $clog2(RW + 1);
  localparam logic signed [VALUE_BITS+2:0] MaxSat =
    (VALUE_BITS+3)'((64'sd1 <<< (VALUE_BITS-1)) - 2);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_DISC, S_ROOT, S_DIV, S_OUT} st_t;
  st_t st;

  logic signed [VALUE_BITS-1:0] s [3];
  logic                         ins;
  logic [1:0]                   run;
  logic [1:0]                   ax;
  logic [SW-1:0]                sq;
  logic signed [VALUE_BITS+2:0] b;
  logic [SW-1:0]                disc;
  logic [RW-1:0]                root;
  logic [SQ_BITS-1:0]           bit_i;
  logic signed [VALUE_BITS+2:0] num;

  logic [VALUE_BITS-1:0] a_abs;
  logic [SW-1:0]         prod;
  logic [SW-1:0]         bb, one_r, sq_r;
  logic [SW:0]           pos_w, neg_w;
  logic [VALUE_BITS+2:0] ub;
  logic [RW-1:0]         trial;
  logic [2*RW-1:0]       tsq;
  logic [1:0]            mi;
  logic signed [VALUE_BITS-1:0] mx;

  always_comb begin
    a_abs = s[ax][VALUE_BITS-1] ? VALUE_BITS'(-s[ax]) : VALUE_BITS'(s[ax]);
    prod  = SW'(a_abs) * SW'(a_abs);
    ub    = b[VALUE_BITS+2] ? (VALUE_BITS+3)'(-b) : (VALUE_BITS+3)'(b);
    bb    = SW'(ub) * SW'(ub);
    one_r = SW'(run) << (2*FRAC_BITS);
    sq_r  = SW'(run) * sq;
    pos_w = (SW+1)'(bb) + (SW+1)'(one_r);
    neg_w = (SW+1)'(sq_r);
    trial = root | (RW'(1) << bit_i);
    tsq   = trial * trial;
    mx = '0;
    mi = '0;
    for (int i = 0; i < AXES; i++) begin
      if (s[i] > mx) begin
        mx = s[i];
        mi = 2'(i);
      end
    end
  end

  assign q_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: if (q_valid) begin
          s   <= q_s;
          ins <= q_inside;
          run <= 2'(AXES);
          if (q_undef) begin
            distance      <= '0;
            all_undefined <= 1'b1;
            out_valid     <= 1'b1;
            st            <= S_OUT;
          end else begin
            ax <= '0;
            sq <= '0;
            b  <= '0;
            st <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= sq + prod;
          b  <= b + (VALUE_BITS+3)'(s[ax]);
          if (ax == 2'(AXES-1)) st <= S_DISC;
          else ax <= ax + 2'd1;
        end
        S_DISC: begin
          if (pos_w < neg_w) begin
            s[mi] <= '0;
            if (run == 2'd1) begin
              distance      <= '0;
              all_undefined <= 1'b0;
              out_valid     <= 1'b1;
              st            <= S_OUT;
            end else begin
              run <= run - 2'd1;
              ax  <= '0;
              sq  <= '0;
              b   <= '0;
              st  <= S_SQ;
            end
          end else begin
            disc  <= SW'(pos_w - neg_w);
            root  <= '0;
            bit_i <= SQ_BITS'(RW-1);
            st    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!(SW'(tsq) > disc) && (tsq >> SW) == 0) root <= trial;
          if (bit_i == '0) st <= S_DIV;
          else bit_i <= bit_i - 1'b1;
        end
        S_DIV: begin
          num <= b + (VALUE_BITS+3)'(root);
          st  <= S_OUT;
          out_valid <= 1'b0;
        end
        S_OUT: begin
          if (!out_valid) begin
            logic signed [VALUE_BITS+2:0] r;
            logic [VALUE_BITS+2:0] an;
            an = num[VALUE_BITS+2] ? (VALUE_BITS+3)'(-num) : (VALUE_BITS+3)'(num);
            // divide by run in {1,2,3}; truncate toward zero
            unique case (run)
              2'd3:    an = (VALUE_BITS+3)'(((2*VALUE_BITS+8)'(an) *
                         (2*VALUE_BITS+8)'(((64'd1 << (VALUE_BITS+4)) + 2) / 3))
                         >> (VALUE_BITS+4));
              2'd2:    an = an >> 1;
              default: an = an;
            endcase
            r = num[VALUE_BITS+2] ? -$signed(an) : $signed(an);
            if (r > MaxSat) r = MaxSat;
            if (r < -MaxSat) r = -MaxSat;
            if (ins) r = -r;
            distance      <= VALUE_BITS'(r);
            all_undefined <= 1'b0;
            out_valid     <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/eikonal_local_update_3d_core.sv]
// channel  | valid/ready          | tdata (low bit up)                               | tuser
// input    | s_tvalid/s_tready    | pos_x,pos_y,pos_z,neg_x,neg_y,neg_z (24b each)   | inside_req
// result   | m_tvalid/m_tready    | distance (24b)                                   | all_undefined
// One word at a time in the solver: each word runs the shared square/accumulate
// step and the bit-serial square root, each dropped axis repeats the square/accumulate
// step, and an all-undefined word skips both.
// A two-entry queue holds classified words while the solver is busy.
// rst is synchronous and clears the queue and solver control.
module eikonal_local_update_3d_core #(
  parameter int VALUE_BITS = elu3_pkg::DefValueBits,
  parameter int FRAC_BITS  = elu3_pkg::DefFracBits,
  parameter int AXES       = elu3_pkg::DefAxes
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((6*VALUE_BITS+7)/8)*8-1:0] s_tdata, // pos_x..neg_z
  input  logic                    s_tuser,  // inside_req
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata, // distance
  output logic                    m_tuser   // all_undefined
);
  import elu3_pkg::*;

  logic signed [VALUE_BITS-1:0] pos_v [3], neg_v [3], q_s [3];
  logic q_valid, q_ready, q_inside, q_undef;
  logic signed [VALUE_BITS-1:0] distance;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_v[i] = s_tdata[i*VALUE_BITS +: VALUE_BITS];
      neg_v[i] = s_tdata[(i+3)*VALUE_BITS +: VALUE_BITS];
    end
  end

  elu3_front #(.VALUE_BITS(VALUE_BITS), .AXES(AXES)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .ins_req(s_tuser),
    .pos_v, .neg_v, .q_valid, .q_ready, .q_inside, .q_undef, .q_s
  );

  elu3_back #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS), .AXES(AXES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_inside, .q_undef, .q_s,
    .out_valid(m_tvalid), .out_ready(m_tready), .distance, .all_undefined(m_tuser)
  );

  assign m_tdata = $bits(m_tdata)'($unsigned(distance));

endmodule

[rtl/core/elu3_checker.sv]
module elu3_checker #(
  parameter int VALUE_BITS = elu3_pkg::DefValueBits
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((VALUE_BITS+7)/8)*8-1:0]       m_tdata,
  input logic                                  m_tuser
);
  localparam logic [VALUE_BITS-1:0] PosCode = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] NegCode = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
  localparam logic [VALUE_BITS-1:0] MinCode = {1'b1, {(VALUE_BITS-1){1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0) else $error("undef nonzero");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[VALUE_BITS-1:0] != PosCode && m_tdata[VALUE_BITS-1:0] != NegCode
      && m_tdata[VALUE_BITS-1:0] != MinCode)
    else $error("sat");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("rst");
endmodule

bind eikonal_local_update_3d_core elu3_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
